// File: src/dvrt_pkg.sv
// Shared types and constants of the distance-vector route table.
// Used by the route store, the neighbor store, the controller and the top level.
// No dependencies.
package dvrt_pkg;

  // Field widths.
  localparam int NODE_W = 4;
  localparam int DIST_W = 24;
  localparam int COST_W = 16;
  localparam int SIL_W  = 8;
  localparam int MASK_W = 16;

  // Packed stream widths; the tdata widths are padded to whole bytes.
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Item modes carried in tuser.
  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_ROW    = 3'd1;
  localparam logic [2:0] MODE_COST   = 3'd2;
  localparam logic [2:0] MODE_TICK   = 3'd3;
  localparam logic [2:0] MODE_LOOKUP = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_NODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNREACHABLE = 2'd2;

  // Reset values and the silence ceiling.
  localparam logic [NODE_W-1:0] OWN_RESET     = 4'd0;
  localparam logic [SIL_W-1:0]  TIMEOUT_RESET = 8'd3;
  localparam logic [DIST_W-1:0] DIST_RESET    = 24'd9999999;
  localparam logic [SIL_W-1:0]  SIL_MAX       = 8'hFF;

  // One route entry.
  typedef struct packed {
    logic [NODE_W-1:0] hop;
    logic              valid;
    logic [DIST_W-1:0] metric;
  } route_ent_t;

  // One neighbor entry.
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              down;
    logic [SIL_W-1:0]  silence;
  } nbr_ent_t;

  // Write requests to the two stores.
  typedef struct packed {
    logic       en;
    route_ent_t data;
  } route_wr_t;

  typedef struct packed {
    logic     en;
    logic     add;
    nbr_ent_t data;
  } nbr_wr_t;

  // What a route entry reads as before its first write.
  localparam route_ent_t ROUTE_RESET = '{hop: '0, valid: 1'b0, metric: DIST_RESET};

endpackage

// File: src/dvrt_route_mem.sv
// Route store: one entry per destination with a registered read port.
// Entries never written read as the reset route; per-entry written bits track that.
// Depends on dvrt_pkg.
module dvrt_route_mem
  import dvrt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  route_wr_t                wr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output route_ent_t               rd_data
);

  route_ent_t             mem [DEPTH];
  logic [DEPTH-1:0]       written_r;
  route_ent_t             rd_q_r;
  logic                   rd_written_r;

  // Write port and written bits.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr.en) begin
      written_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port, read-first on a same-address write.
  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_written_r <= 1'b0;
    end else begin
      rd_written_r <= written_r[rd_addr];
    end
  end

  assign rd_data = rd_written_r ? rd_q_r : ROUTE_RESET;

endmodule

// File: src/dvrt_nbr_mem.sv
// Neighbor store: link cost, link state and silence count per neighbor.
// Present bits live in flops; the rest is a memory with a registered read port.
// Depends on dvrt_pkg.
module dvrt_nbr_mem
  import dvrt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nbr_wr_t                  wr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output nbr_ent_t                 rd_data,
  output logic                     rd_present
);

  nbr_ent_t         mem [DEPTH];
  logic [DEPTH-1:0] present_r;
  nbr_ent_t         rd_q_r;
  logic             rd_present_r;

  // Entry data; only meaningful once the neighbor has been added.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // A neighbor becomes present on its first add and stays so.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (wr.en && wr.add) begin
      present_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_present_r <= 1'b0;
    end else begin
      rd_present_r <= present_r[rd_addr];
    end
  end

  assign rd_data    = rd_q_r;
  assign rd_present = rd_present_r;

endmodule

// File: src/dvrt_ctrl.sv
// Sequencer of the route table: decodes items, runs read-modify-write passes
// over the route and neighbor stores, holds configuration and the output register.
// Depends on dvrt_pkg; drives dvrt_route_mem and dvrt_nbr_mem.
module dvrt_ctrl
  import dvrt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TUSER_W-1:0]    in_tuser,
  input  logic [IN_TDATA_W-1:0]    in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_TDATA_W-1:0]   out_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output route_wr_t                rt_wr,
  output logic [$clog2(SLOTS)-1:0] rt_waddr,
  output logic [$clog2(SLOTS)-1:0] rt_raddr,
  input  route_ent_t               rt_rd,
  output nbr_wr_t                  nbr_wr,
  output logic [$clog2(SLOTS)-1:0] nbr_waddr,
  output logic [$clog2(SLOTS)-1:0] nbr_raddr,
  input  nbr_ent_t                 nbr_rd,
  input  logic                     nbr_rd_present
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ROW_CHK = 4'd1;
  localparam logic [3:0] ST_ROW_RD  = 4'd2;
  localparam logic [3:0] ST_ROW_UPD = 4'd3;
  localparam logic [3:0] ST_CC_CHK  = 4'd4;
  localparam logic [3:0] ST_TK_NBR  = 4'd5;
  localparam logic [3:0] ST_SCAN_RT = 4'd6;
  localparam logic [3:0] ST_LK_RES  = 4'd7;
  localparam logic [3:0] ST_FIN     = 4'd8;

  // True when a node index names a stored entry.
  function automatic logic in_range(input logic [NODE_W-1:0] x);
    return {28'd0, x} < 32'(SLOTS);
  endfunction

  // Clamp a grown distance to the unreachable value.
  function automatic logic [DIST_W-1:0] sat_dist(input logic [DIST_W:0] v,
                                                 input logic [DIST_W-1:0] lim);
    return (v > {1'b0, lim}) ? lim : v[DIST_W-1:0];
  endfunction

  // Input fields, lowest bits first.
  logic [2:0]        in_mode;
  logic [NODE_W-1:0] in_n, in_d, in_rhop;
  logic              in_rnone, in_first;
  logic [DIST_W-1:0] in_rdist;
  logic [COST_W-1:0] in_cost;

  assign in_mode  = in_tuser;
  assign in_n     = in_tdata[3:0];
  assign in_d     = in_tdata[7:4];
  assign in_rhop  = in_tdata[11:8];
  assign in_rnone = in_tdata[12];
  assign in_rdist = in_tdata[36:13];
  assign in_first = in_tdata[37];
  assign in_cost  = in_tdata[53:38];

  logic [3:0]             state_r, state_nxt;
  logic [2:0]             mode_r, mode_nxt;
  logic [NODE_W-1:0]      n_r, n_nxt, d_r, d_nxt, rhop_r, rhop_nxt;
  logic                   rnone_r, rnone_nxt, first_r, first_nxt;
  logic [DIST_W-1:0]      rdist_r, rdist_nxt;
  logic [COST_W-1:0]      cost_r, cost_nxt;
  logic signed [COST_W:0] diff_r, diff_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [SLOTS-1:0]       mask_r, mask_nxt;
  route_ent_t             res_r, res_nxt;
  logic                   res_at_r, res_at_nxt;
  logic [NODE_W-1:0]      own_r, own_nxt;
  logic [SIL_W-1:0]       tmo_r, tmo_nxt;
  logic [DIST_W-1:0]      unr_r, unr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Datapath terms.
  logic [DIST_W-1:0]      link_dist;
  logic [DIST_W-1:0]      row_sum;
  logic signed [DIST_W+1:0] shifted;
  logic [DIST_W-1:0]      shifted_sat;
  logic [SIL_W-1:0]       sil_inc;
  logic                   drop;
  logic [SLOTS-1:0]       mask_now;
  logic                   own_slot;

  assign link_dist = sat_dist({9'd0, nbr_rd.cost}, unr_r);
  assign row_sum   = sat_dist({9'd0, cost_r} + {1'b0, rdist_r}, unr_r);
  assign shifted   = $signed({2'b00, rt_rd.metric}) + {{9{diff_r[COST_W]}}, diff_r};
  assign shifted_sat = shifted[DIST_W+1] ? '0
                     : sat_dist(shifted[DIST_W:0], unr_r);
  assign sil_inc   = (nbr_rd.silence == SIL_MAX) ? SIL_MAX : nbr_rd.silence + 8'd1;
  assign drop      = nbr_rd_present && (sil_inc > tmo_r) && !nbr_rd.down;
  assign own_slot  = (own_r == NODE_W'(idx_r));

  always_comb begin
    mask_now        = mask_r;
    mask_now[idx_r] = mask_r[idx_r] | drop;
  end

  // Next state and store accesses.
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    rhop_nxt      = rhop_r;
    rnone_nxt     = rnone_r;
    first_nxt     = first_r;
    rdist_nxt     = rdist_r;
    cost_nxt      = cost_r;
    diff_nxt      = diff_r;
    idx_nxt       = idx_r;
    mask_nxt      = mask_r;
    res_nxt       = res_r;
    res_at_nxt    = res_at_r;
    own_nxt       = own_r;
    tmo_nxt       = tmo_r;
    unr_nxt       = unr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rt_wr         = '0;
    nbr_wr        = '0;
    rt_waddr      = idx_r;
    rt_raddr      = idx_r;
    nbr_waddr     = idx_r;
    nbr_raddr     = idx_r;

    // Configuration writes.
    if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_NODE:    own_nxt = cfg_data[NODE_W-1:0];
        CFG_TIMEOUT:     tmo_nxt = cfg_data[SIL_W-1:0];
        CFG_UNREACHABLE: unr_nxt = cfg_data;
        default: ;
      endcase
    end

    // The output register empties when the receiver takes the item.
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt   = in_mode;
          n_nxt      = in_n;
          d_nxt      = in_d;
          rhop_nxt   = in_rhop;
          rnone_nxt  = in_rnone;
          first_nxt  = in_first;
          rdist_nxt  = in_rdist;
          cost_nxt   = in_cost;
          mask_nxt   = '0;
          res_nxt    = '0;
          res_at_nxt = 1'b0;
          state_nxt  = ST_FIN;
          case (in_mode)
            MODE_ADD: begin
              if (in_range(in_n) && in_n != own_r) begin
                nbr_wr.en    = 1'b1;
                nbr_wr.add   = 1'b1;
                nbr_wr.data  = '{cost: in_cost, down: 1'b0, silence: '0};
                nbr_waddr    = IDX_W'(in_n);
                rt_wr.en     = 1'b1;
                rt_wr.data   = '{hop: in_n, valid: 1'b1,
                                 metric: sat_dist({9'd0, in_cost}, unr_r)};
                rt_waddr     = IDX_W'(in_n);
              end
            end
            MODE_ROW: begin
              if (in_range(in_n) && in_n != own_r) begin
                nbr_raddr = IDX_W'(in_n);
                rt_raddr  = IDX_W'(in_n);
                state_nxt = ST_ROW_CHK;
              end
            end
            MODE_COST: begin
              if (in_range(in_n) && in_n != own_r) begin
                nbr_raddr = IDX_W'(in_n);
                state_nxt = ST_CC_CHK;
              end
            end
            MODE_TICK: begin
              nbr_raddr = '0;
              idx_nxt   = '0;
              state_nxt = ST_TK_NBR;
            end
            MODE_LOOKUP: begin
              if (in_d == own_r) begin
                res_nxt    = '{hop: own_r, valid: 1'b1, metric: '0};
                res_at_nxt = 1'b1;
              end else if (in_range(in_d)) begin
                rt_raddr  = IDX_W'(in_d);
                state_nxt = ST_LK_RES;
              end else begin
                res_nxt.metric = unr_r;
              end
            end
            default: ;
          endcase
        end
      end

      // Neighbor and its own route are in; handle the heard-again case.
      ST_ROW_CHK: begin
        state_nxt = ST_FIN;
        if (nbr_rd_present) begin
          // From here on the cost register holds the neighbor's link cost.
          cost_nxt  = nbr_rd.cost;
          nbr_waddr = IDX_W'(n_r);
          rt_waddr  = IDX_W'(n_r);
          if (first_r) begin
            nbr_wr.en   = 1'b1;
            nbr_wr.data = '{cost: nbr_rd.cost, down: 1'b0, silence: '0};
            if (nbr_rd.down && rt_rd.metric > link_dist) begin
              rt_wr.en   = 1'b1;
              rt_wr.data = '{hop: n_r, valid: 1'b1, metric: link_dist};
            end
          end
          if (in_range(d_r) && d_r != own_r) begin
            state_nxt = ST_ROW_RD;
          end
        end
      end

      ST_ROW_RD: begin
        rt_raddr  = IDX_W'(d_r);
        state_nxt = ST_ROW_UPD;
      end

      // Forced update, split horizon or better-distance replace.
      ST_ROW_UPD: begin
        rt_waddr = IDX_W'(d_r);
        if (rt_rd.valid && rt_rd.hop == n_r) begin
          rt_wr.en   = 1'b1;
          rt_wr.data = '{hop: rt_rd.hop, valid: 1'b1, metric: row_sum};
        end else if (!rnone_r && rhop_r == own_r) begin
          rt_wr.en = 1'b0;
        end else if (rt_rd.metric > row_sum) begin
          rt_wr.en   = 1'b1;
          rt_wr.data = '{hop: n_r, valid: 1'b1, metric: row_sum};
        end
        state_nxt = ST_FIN;
      end

      // Store the new cost; an up link starts a route pass.
      ST_CC_CHK: begin
        state_nxt = ST_FIN;
        if (nbr_rd_present) begin
          nbr_wr.en   = 1'b1;
          nbr_wr.data = '{cost: cost_r, down: nbr_rd.down, silence: nbr_rd.silence};
          nbr_waddr   = IDX_W'(n_r);
          if (!nbr_rd.down) begin
            diff_nxt  = $signed({1'b0, cost_r}) - $signed({1'b0, nbr_rd.cost});
            rt_raddr  = '0;
            idx_nxt   = '0;
            state_nxt = ST_SCAN_RT;
          end
        end
      end

      // Neighbor pass of a tick: one entry a cycle.
      ST_TK_NBR: begin
        if (nbr_rd_present) begin
          nbr_wr.en   = 1'b1;
          nbr_wr.data = '{cost: nbr_rd.cost, down: nbr_rd.down | drop, silence: sil_inc};
        end
        mask_nxt  = mask_now;
        nbr_raddr = IDX_W'(idx_r + 1'b1);
        if (idx_r == LAST_IDX) begin
          if (mask_now != '0) begin
            rt_raddr  = '0;
            idx_nxt   = '0;
            state_nxt = ST_SCAN_RT;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
        end
      end

      // Route pass: drop routes of downed links, or shift by a cost change.
      ST_SCAN_RT: begin
        if (!own_slot && rt_rd.valid) begin
          if (mode_r == MODE_TICK) begin
            if (mask_r[IDX_W'(rt_rd.hop)]) begin
              rt_wr.en   = 1'b1;
              rt_wr.data = '{hop: '0, valid: 1'b0, metric: unr_r};
            end
          end else if (rt_rd.hop == n_r) begin
            rt_wr.en   = 1'b1;
            rt_wr.data = '{hop: rt_rd.hop, valid: 1'b1,
                           metric: (rt_rd.metric >= unr_r) ? unr_r : shifted_sat};
          end
        end
        rt_raddr = IDX_W'(idx_r + 1'b1);
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
        end
      end

      ST_LK_RES: begin
        res_nxt   = rt_rd;
        state_nxt = ST_FIN;
      end

      // Hand the result to the output register once it has room.
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00,
                           (mode_r == MODE_TICK) ? MASK_W'(mask_r) : {MASK_W{1'b0}},
                           res_at_r, res_r.metric, res_r.valid, res_r.hop};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      own_r       <= OWN_RESET;
      tmo_r       <= TIMEOUT_RESET;
      unr_r       <= DIST_RESET;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
      idx_r       <= '0;
      mode_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      own_r       <= own_nxt;
      tmo_r       <= tmo_nxt;
      unr_r       <= unr_nxt;
      out_valid_r <= out_valid_nxt;
      mask_r      <= mask_nxt;
      idx_r       <= idx_nxt;
      mode_r      <= mode_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    rhop_r     <= rhop_nxt;
    rnone_r    <= rnone_nxt;
    first_r    <= first_nxt;
    rdist_r    <= rdist_nxt;
    cost_r     <= cost_nxt;
    diff_r     <= diff_nxt;
    res_r      <= res_nxt;
    res_at_r   <= res_at_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

endmodule

// File: src/distance_vector_route_table.sv
// Top level of the distance-vector route table.
// Instantiates dvrt_ctrl, dvrt_route_mem and dvrt_nbr_mem; depends on dvrt_pkg.
//
// Use:
//   in_*  : one item per handshake; in_tuser is the mode (add neighbor, advertised
//           row, cost change, tick, lookup). Every item yields exactly one result.
//   out_* : one result item per input item, in order.
//   cfg_* : register writes (own node, timeout ticks, unreachable distance),
//           accepted every cycle; write only while no item is in progress.
// With min(NODES, 16) table entries: a cost change on an up link scans every route
// entry, and a tick scans every neighbor entry, then every route entry as well when a link goes down.
// A new item is taken in the cycle after the previous result moved into the
// output register, so one item is worked on at a time. Scans are paced by the
// single read port of each store: one entry per cycle.
// Reset clears the written and present bits at once: routes read unreachable
// with no next hop, no neighbor is present. No clearing pass is needed.
// If the receiver stalls, the result waits in the output register; the next
// item is still taken and worked on, and waits for the register to free up.
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int NODES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // mode[2:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // neighbor[3:0], destination[7:4], row_next_hop[11:8], row_next_hop_none[12],
  // row_distance[36:13], first_row[37], link_cost[53:38], zero pad[55:54]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // next_hop[3:0], next_hop_valid[4], route_distance_out[28:5],
  // at_destination[29], links_dropped[45:30], zero pad[47:46]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Node indexes are four bits wide, so no more than sixteen entries are reachable.
  localparam int SLOTS = (NODES < 16) ? NODES : 16;
  localparam int IDX_W = $clog2(SLOTS);

  route_wr_t        rt_wr;
  logic [IDX_W-1:0] rt_waddr, rt_raddr;
  route_ent_t       rt_rd;
  nbr_wr_t          nbr_wr;
  logic [IDX_W-1:0] nbr_waddr, nbr_raddr;
  nbr_ent_t         nbr_rd;
  logic             nbr_rd_present;

  // Sequencer.
  dvrt_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tuser       (in_tuser),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rt_wr          (rt_wr),
    .rt_waddr       (rt_waddr),
    .rt_raddr       (rt_raddr),
    .rt_rd          (rt_rd),
    .nbr_wr         (nbr_wr),
    .nbr_waddr      (nbr_waddr),
    .nbr_raddr      (nbr_raddr),
    .nbr_rd         (nbr_rd),
    .nbr_rd_present (nbr_rd_present)
  );

  // Route store.
  dvrt_route_mem #(.DEPTH(SLOTS)) u_route_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (rt_wr),
    .wr_addr (rt_waddr),
    .rd_addr (rt_raddr),
    .rd_data (rt_rd)
  );

  // Neighbor store.
  dvrt_nbr_mem #(.DEPTH(SLOTS)) u_nbr_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (nbr_wr),
    .wr_addr    (nbr_waddr),
    .rd_addr    (nbr_raddr),
    .rd_data    (nbr_rd),
    .rd_present (nbr_rd_present)
  );

endmodule

// File: src/dvrt_chk.sv
// Port-level checker for the distance-vector route table, bound to the top level.
// Depends on dvrt_pkg for stream widths.
module dvrt_chk
  import dvrt_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // Items accepted but not yet delivered.
  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // Results only for accepted items, and at most one waiting plus one in work.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || pend_r != 2'd0) && pend_r != 2'd3)
    else $error("result count does not match accepted items");

  // The own-node answer is a valid hop at distance zero.
  a_own_route: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[29] |-> out_tdata[4] && out_tdata[28:5] == 24'd0)
    else $error("own-node lookup answer malformed");

  // A tick result carries no lookup answer.
  a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[45:30] != 16'd0 |-> out_tdata[29:0] == 30'd0)
    else $error("dropped-link mask mixed with lookup fields");

endmodule

bind distance_vector_route_table dvrt_chk u_dvrt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the distance-vector route table, with an item-level predictor.
// Needs dvrt_pkg and distance_vector_route_table; reads no files.
module testbench;
  import dvrt_pkg::*;

  localparam int NODE_COUNT  = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * NODE_COUNT + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT = 12;
  localparam logic [2:0] MODE_UNUSED_FIRST = MODE_LOOKUP + 3'd1;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  // One input item, split into its fields.
  typedef struct packed {
    logic [2:0]        mode;
    logic [NODE_W-1:0] neighbor;
    logic [NODE_W-1:0] destination;
    logic [NODE_W-1:0] row_next_hop;
    logic              row_next_hop_none;
    logic [DIST_W-1:0] row_distance;
    logic              first_row;
    logic [COST_W-1:0] link_cost;
  } route_item_t;

  // One result item, split into its fields.
  typedef struct packed {
    logic [NODE_W-1:0] next_hop;
    logic              next_hop_valid;
    logic [DIST_W-1:0] distance;
    logic              at_destination;
    logic [MASK_W-1:0] links_dropped;
  } route_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted register settings.
  logic [NODE_W-1:0] own_node;
  logic [SIL_W-1:0]  timeout_ticks;
  logic [DIST_W-1:0] unreach_dist;

  // Predicted route and neighbor tables.
  logic [NODE_W-1:0] route_hop     [NODE_COUNT];
  logic              route_valid   [NODE_COUNT];
  logic [DIST_W-1:0] route_dist    [NODE_COUNT];
  logic [COST_W-1:0] nbr_cost      [NODE_COUNT];
  logic              nbr_present   [NODE_COUNT];
  logic              nbr_down      [NODE_COUNT];
  logic [SIL_W-1:0]  nbr_silence   [NODE_COUNT];

  route_answer_t pending_answers[$];
  int items_sent = 0;
  int answers_seen = 0;
  int failures = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  distance_vector_route_table #(.NODES(NODE_COUNT)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Clears the predicted tables and settings as reset does.
  function automatic void reset_route_model();
    own_node = OWN_RESET;
    timeout_ticks = TIMEOUT_RESET;
    unreach_dist = DIST_RESET;
    for (int i = 0; i < NODE_COUNT; i++) begin
      route_hop[i] = '0;
      route_valid[i] = 1'b0;
      route_dist[i] = DIST_RESET;
      nbr_cost[i] = '0;
      nbr_present[i] = 1'b0;
      nbr_down[i] = 1'b0;
      nbr_silence[i] = '0;
    end
  endfunction

  // Saturates a sum at the unreachable distance.
  function automatic logic [DIST_W-1:0] clamp_dist(input logic [DIST_W:0] v);
    return (v > {1'b0, unreach_dist}) ? unreach_dist : v[DIST_W-1:0];
  endfunction

  // Applies one item to the predicted tables and returns the answer it yields.
  function automatic route_answer_t predict_route_step(input route_item_t it);
    route_answer_t ans;
    logic [NODE_W-1:0] n;
    logic [NODE_W-1:0] d;
    logic [DIST_W-1:0] c;
    logic [DIST_W-1:0] sum;
    int shifted;
    ans = '0;
    n = it.neighbor;
    d = it.destination;
    case (it.mode)
      MODE_ADD: begin
        if (n != own_node) begin
          nbr_present[n] = 1'b1;
          nbr_cost[n] = it.link_cost;
          nbr_down[n] = 1'b0;
          nbr_silence[n] = '0;
          route_hop[n] = n;
          route_valid[n] = 1'b1;
          route_dist[n] = clamp_dist({9'b0, it.link_cost});
        end
      end
      MODE_ROW: begin
        if (n != own_node && nbr_present[n]) begin
          // Hearing the first row revives a down link.
          if (it.first_row) begin
            nbr_silence[n] = '0;
            if (nbr_down[n]) begin
              c = clamp_dist({9'b0, nbr_cost[n]});
              nbr_down[n] = 1'b0;
              if (route_dist[n] > c) begin
                route_dist[n] = c;
                route_hop[n] = n;
                route_valid[n] = 1'b1;
              end
            end
          end
          if (d != own_node) begin
            sum = clamp_dist({9'b0, nbr_cost[n]} +
                             {1'b0, clamp_dist({1'b0, it.row_distance})});
            if (route_valid[d] && route_hop[d] == n) begin
              route_dist[d] = sum;
            end else if (!it.row_next_hop_none && it.row_next_hop == own_node) begin
              // The neighbor routes back through us: split horizon skips it.
            end else if (route_dist[d] > sum) begin
              route_dist[d] = sum;
              route_hop[d] = n;
              route_valid[d] = 1'b1;
            end
          end
        end
      end
      MODE_COST: begin
        if (n != own_node && nbr_present[n]) begin
          if (!nbr_down[n]) begin
            for (int i = 0; i < NODE_COUNT; i++) begin
              if (i != own_node && route_valid[i] && route_hop[i] == n) begin
                if (route_dist[i] >= unreach_dist) begin
                  route_dist[i] = unreach_dist;
                end else begin
                  shifted = int'(route_dist[i]) + int'(it.link_cost) - int'(nbr_cost[n]);
                  if (shifted < 0) shifted = 0;
                  route_dist[i] = clamp_dist((DIST_W+1)'(shifted));
                end
              end
            end
          end
          nbr_cost[n] = it.link_cost;
        end
      end
      MODE_TICK: begin
        for (int k = 0; k < NODE_COUNT; k++) begin
          if (nbr_present[k]) begin
            if (nbr_silence[k] != SIL_MAX) nbr_silence[k] = nbr_silence[k] + 1'b1;
            if (nbr_silence[k] > timeout_ticks && !nbr_down[k]) begin
              nbr_down[k] = 1'b1;
              ans.links_dropped[k] = 1'b1;
              for (int i = 0; i < NODE_COUNT; i++) begin
                if (i != own_node && route_valid[i] && route_hop[i] == k) begin
                  route_hop[i] = '0;
                  route_valid[i] = 1'b0;
                  route_dist[i] = unreach_dist;
                end
              end
            end
          end
        end
      end
      MODE_LOOKUP: begin
        if (d == own_node) begin
          ans.next_hop = own_node;
          ans.next_hop_valid = 1'b1;
          ans.at_destination = 1'b1;
        end else begin
          ans.next_hop = route_hop[d];
          ans.next_hop_valid = route_valid[d];
          ans.distance = route_dist[d];
        end
      end
      default: begin
        // Unused modes leave the tables alone and answer all zero.
      end
    endcase
    return ans;
  endfunction

  function automatic route_item_t make_item(input logic [2:0] mode,
                                            input logic [NODE_W-1:0] nbr,
                                            input logic [NODE_W-1:0] dest,
                                            input logic [NODE_W-1:0] rhop,
                                            input logic rnone,
                                            input logic [DIST_W-1:0] rdist,
                                            input logic first,
                                            input logic [COST_W-1:0] cost);
    return '{mode: mode, neighbor: nbr, destination: dest, row_next_hop: rhop,
             row_next_hop_none: rnone, row_distance: rdist, first_row: first,
             link_cost: cost};
  endfunction

  // Mostly a small pool of neighbors, so that rows find present ones.
  function automatic logic [NODE_W-1:0] pick_neighbor();
    if ($urandom_range(0, 99) < 80) return NODE_W'($urandom_range(0, 7));
    return NODE_W'($urandom_range(0, NODE_COUNT - 1));
  endfunction

  function automatic logic [NODE_W-1:0] rand_next_hop();
    if ($urandom_range(0, 99) < 30) return own_node;
    return NODE_W'($urandom_range(0, NODE_COUNT - 1));
  endfunction

  // Small distances, with full-range and near-unreachable ones mixed in.
  function automatic logic [DIST_W-1:0] rand_distance();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return DIST_W'($urandom_range(0, 300));
    if (pick < 85) return DIST_W'($urandom);
    return unreach_dist + DIST_W'($urandom_range(0, 4)) - DIST_W'(2);
  endfunction

  function automatic logic [COST_W-1:0] rand_cost();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return COST_W'($urandom_range(0, 100));
    if (pick < 90) return COST_W'($urandom);
    return (pick < 95) ? '0 : '1;
  endfunction

  // Offers one item, waits for its handshake and records the predicted answer.
  task automatic send_route_item(input route_item_t it);
    route_answer_t expected;
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.mode;
    in_tdata <= {2'b00, it.link_cost, it.first_row, it.row_distance, it.row_next_hop_none,
                 it.row_next_hop, it.destination, it.neighbor};
    do @(posedge clk); while (!in_tready);
    expected = predict_route_step(it);
    pending_answers = {pending_answers, expected};
    items_sent++;
  endtask

  // Lets every outstanding answer arrive, then a settling pause.
  task automatic drain_route_items();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_route_reg(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OWN_NODE:    own_node = val[NODE_W-1:0];
      CFG_TIMEOUT:     timeout_ticks = val[SIL_W-1:0];
      CFG_UNREACHABLE: unreach_dist = val[DIST_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_route_config(input logic [NODE_W-1:0] own, input logic [SIL_W-1:0] tmo,
                                  input logic [DIST_W-1:0] unr);
    drain_route_items();
    write_route_reg(CFG_OWN_NODE, CFG_DATA_W'(own));
    write_route_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
    write_route_reg(CFG_UNREACHABLE, unr);
  endtask

  // Random traffic: mostly advertisements, with ticks, lookups and noise between.
  task automatic run_route_traffic(input int count);
    int stop_at;
    int pick;
    int rows;
    logic [NODE_W-1:0] nbr;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_route_item(make_item(MODE_ADD, pick_neighbor(), NODE_W'($urandom),
                                  NODE_W'($urandom), 1'($urandom), DIST_W'($urandom),
                                  1'($urandom), rand_cost()));
      end else if (pick < 55) begin
        nbr = pick_neighbor();
        rows = $urandom_range(1, 6);
        for (int i = 0; i < rows; i++) begin
          send_route_item(make_item(MODE_ROW, nbr, NODE_W'($urandom_range(0, NODE_COUNT - 1)),
                                    rand_next_hop(), $urandom_range(0, 4) == 0,
                                    rand_distance(),
                                    (i == 0) && ($urandom_range(0, 9) != 0),
                                    COST_W'($urandom)));
        end
      end else if (pick < 63) begin
        send_route_item(make_item(MODE_COST, pick_neighbor(), NODE_W'($urandom),
                                  NODE_W'($urandom), 1'($urandom), DIST_W'($urandom),
                                  1'($urandom), rand_cost()));
      end else if (pick < 72) begin
        send_route_item(make_item(MODE_TICK, NODE_W'($urandom), NODE_W'($urandom),
                                  NODE_W'($urandom), 1'($urandom), DIST_W'($urandom),
                                  1'($urandom), COST_W'($urandom)));
      end else if (pick < 94) begin
        send_route_item(make_item(MODE_LOOKUP, NODE_W'($urandom),
                                  NODE_W'($urandom_range(0, NODE_COUNT - 1)),
                                  NODE_W'($urandom), 1'($urandom), DIST_W'($urandom),
                                  1'($urandom), COST_W'($urandom)));
      end else if (pick < 97) begin
        send_route_item(make_item(3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                                  NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                                  1'($urandom), DIST_W'($urandom), 1'($urandom),
                                  COST_W'($urandom)));
      end else begin
        send_route_item(make_item(3'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                                  NODE_W'($urandom), 1'($urandom), DIST_W'($urandom),
                                  1'($urandom), COST_W'($urandom)));
      end
    end
  endtask

  // Lookups right after reset: own route and an empty entry.
  task automatic test_lookup_after_reset();
    send_route_item(make_item(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 0));
    send_route_item(make_item(MODE_LOOKUP, 0, 5, 0, 0, 0, 0, 0));
  endtask

  // Neighbor adds at the cost extremes, and one naming this router.
  task automatic test_neighbor_add();
    send_route_item(make_item(MODE_ADD, own_node, 0, 0, 0, 0, 0, 16'd77));
    send_route_item(make_item(MODE_ADD, 1, 0, 0, 0, 0, 0, 16'd10));
    send_route_item(make_item(MODE_ADD, 2, 0, 0, 0, 0, 0, '1));
    send_route_item(make_item(MODE_ADD, 15, 0, 0, 0, 0, 0, '0));
  endtask

  // Rows: new route, worse offer, split horizon, better offer, forced update, ignored rows.
  task automatic test_advertised_rows();
    send_route_item(make_item(MODE_ROW, 1, 5, 3, 0, 24'd20, 1, 0));
    send_route_item(make_item(MODE_ROW, 2, 5, 3, 0, 24'd0, 1, 0));
    send_route_item(make_item(MODE_ROW, 15, 5, own_node, 0, 24'd0, 1, 0));
    send_route_item(make_item(MODE_ROW, 15, 5, own_node, 1, 24'd5, 0, 0));
    send_route_item(make_item(MODE_ROW, 15, 5, 4, 0, '1, 0, 0));
    send_route_item(make_item(MODE_ROW, 3, 6, 4, 0, 24'd1, 1, 0));
    send_route_item(make_item(MODE_ROW, 1, own_node, 4, 0, 24'd1, 0, 0));
  endtask

  // Cost changes down to zero, on an absent neighbor, then a lookup.
  task automatic test_cost_change();
    send_route_item(make_item(MODE_COST, 1, 0, 0, 0, 0, 0, '0));
    send_route_item(make_item(MODE_COST, 2, 0, 0, 0, 0, 0, '0));
    send_route_item(make_item(MODE_COST, 7, 0, 0, 0, 0, 0, 16'd9));
    send_route_item(make_item(MODE_LOOKUP, 0, 5, 0, 0, 0, 0, 0));
  endtask

  // Ticks until every link drops, then one link revives and a down link gets a new cost.
  task automatic test_link_timeout();
    repeat (4) send_route_item(make_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_route_item(make_item(MODE_ROW, 1, 4, 4, 1, 24'd3, 1, 0));
    send_route_item(make_item(MODE_COST, 2, 0, 0, 0, 0, 0, 16'd40));
    send_route_item(make_item(MODE_LOOKUP, 0, 1, 0, 0, 0, 0, 0));
    send_route_item(make_item(MODE_LOOKUP, 0, 2, 0, 0, 0, 0, 0));
  endtask

  task automatic test_unknown_mode();
    send_route_item(make_item(MODE_UNUSED_LAST, '1, '1, '1, 1, '1, 1, '1));
  endtask

  task automatic test_traffic_reset_config();
    run_route_traffic(400);
  endtask

  // Lowest timeout, an unreachable distance of one, highest node index.
  task automatic test_config_low_extremes();
    set_route_config(4'd15, 8'd0, 24'd1);
    run_route_traffic(200);
  endtask

  // Links never time out and distances span the full range; no idling in this stretch.
  task automatic test_config_high_extremes();
    set_route_config(4'd7, 8'd255, 24'hFFFFFF);
    no_idle = 1'b1;
    run_route_traffic(300);
    no_idle = 1'b0;
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_backpressure();
    set_route_config(NODE_W'($urandom_range(0, NODE_COUNT - 1)),
                     SIL_W'($urandom_range(1, 6)), DIST_W'($urandom_range(50, 5000)));
    hold_req = 1'b1;
    run_route_traffic(300);
  endtask

  task automatic test_config_mid();
    set_route_config(4'd0, 8'd3, 24'd1000);
    run_route_traffic(200);
  endtask

  // Result receiver: random stalls, a no-idle stretch and one long hold-off.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compares each accepted result item with the oldest predicted answer.
  always @(posedge clk) begin
    route_answer_t got;
    route_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{next_hop: out_tdata[3:0], next_hop_valid: out_tdata[4],
              distance: out_tdata[28:5], at_destination: out_tdata[29],
              links_dropped: out_tdata[45:30]};
      if (pending_answers.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result %0d arrived with no item outstanding", answers_seen);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display("result %0d: expected hop %0d/%0b dist %0d at_dest %0b dropped %h, got %0d/%0b dist %0d at_dest %0b dropped %h",
                     answers_seen, want.next_hop, want.next_hop_valid, want.distance,
                     want.at_destination, want.links_dropped, got.next_hop,
                     got.next_hop_valid, got.distance, got.at_destination,
                     got.links_dropped);
        end
      end
      answers_seen++;
    end
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    reset_route_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_lookup_after_reset();
    test_neighbor_add();
    test_advertised_rows();
    test_cost_change();
    test_link_timeout();
    test_unknown_mode();
    test_traffic_reset_config();
    test_config_low_extremes();
    test_config_high_extremes();
    test_output_backpressure();
    test_config_mid();
    drain_route_items();
    if (failures == 0 && pending_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/dvrt_pkg.sv
src/dvrt_route_mem.sv
src/dvrt_nbr_mem.sv
src/dvrt_ctrl.sv
src/distance_vector_route_table.sv
src/dvrt_chk.sv
tb/sv/testbench.sv
